// ===== design/ps2mt_pkg.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker package
// Shared types, constants and register indexes for the packet tracker.
// ----------------------------------------------------------------------------
package ps2mt_pkg;

	// Internal cursor coordinate width; the clamp limit never exceeds its range.
	localparam int COORD_BITS = 12;
	// Fixed widths of the register and result fields.
	localparam int LIMIT_W  = 12;
	localparam int CURSOR_W = 12;
	// Signed width that holds a coordinate, a limit and an 8-bit delta.
	localparam int SUM_W = ((COORD_BITS > LIMIT_W) ? COORD_BITS : LIMIT_W) + 2;

	localparam logic [COORD_BITS-1:0] COORD_MASK = {COORD_BITS{1'b1}};

	// Configuration register indexes.
	localparam logic REG_MAX_X = 1'b0;
	localparam logic REG_MAX_Y = 1'b1;

	localparam logic [LIMIT_W-1:0] RESET_MAX_X = LIMIT_W'(799);
	localparam logic [LIMIT_W-1:0] RESET_MAX_Y = LIMIT_W'(599);
	localparam logic [COORD_BITS-1:0] RESET_POS_X = COORD_BITS'(400);
	localparam logic [COORD_BITS-1:0] RESET_POS_Y = COORD_BITS'(300);

	// Header bit positions.
	localparam int HDR_LEFT_BIT  = 0;
	localparam int HDR_RIGHT_BIT = 1;
	localparam int HDR_VALID_BIT = 3;

	// Input action codes.
	localparam logic ACT_BYTE    = 1'b0;
	localparam logic ACT_CONSUME = 1'b1;

	// Packet slot codes.
	localparam logic [1:0] SLOT_HEADER = 2'd0;
	localparam logic [1:0] SLOT_DX     = 2'd1;
	localparam logic [1:0] SLOT_DY     = 2'd2;

	typedef struct packed {
		logic       action;
		logic [7:0] rx_byte;
	} in_item_t;

	typedef struct packed {
		logic [CURSOR_W-1:0] cursor_x;
		logic [CURSOR_W-1:0] cursor_y;
		logic                left_down;
		logic                right_down;
		logic                click_pending;
		logic                click_taken;
	} out_item_t;

	typedef struct packed {
		logic [1:0]            byte_slot;
		logic [7:0]            header_byte;
		logic [7:0]            dx_byte;
		logic [COORD_BITS-1:0] pos_x;
		logic [COORD_BITS-1:0] pos_y;
		logic                  left_state;
		logic                  right_state;
		logic                  click_flag;
	} trk_state_t;

endpackage

// ===== design/ps2mt_update.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker update logic
// Computes the next tracker state and the result for one registered item.
// ----------------------------------------------------------------------------
module ps2mt_update (
	input  ps2mt_pkg::in_item_t               item,
	input  ps2mt_pkg::trk_state_t             cur,
	input  logic [ps2mt_pkg::LIMIT_W-1:0]     max_x,
	input  logic [ps2mt_pkg::LIMIT_W-1:0]     max_y,
	output ps2mt_pkg::trk_state_t             nxt,
	output ps2mt_pkg::out_item_t              result
);

	localparam int SW = ps2mt_pkg::SUM_W;
	localparam int CW = ps2mt_pkg::COORD_BITS;

	logic signed [SW-1:0] sum_x;
	logic signed [SW-1:0] sum_y;
	logic signed [SW-1:0] lim_x;
	logic signed [SW-1:0] lim_y;
	logic signed [SW-1:0] mask_w;
	logic [CW-1:0]        clamp_x;
	logic [CW-1:0]        clamp_y;
	logic                 taken;

	assign mask_w = SW'(ps2mt_pkg::COORD_MASK);
	assign lim_x  = (SW'(max_x) > mask_w) ? mask_w : SW'(max_x);
	assign lim_y  = (SW'(max_y) > mask_w) ? mask_w : SW'(max_y);

	// Zero-extended position plus or minus the sign-extended delta.
	assign sum_x = SW'(cur.pos_x) + SW'($signed(cur.dx_byte));
	assign sum_y = SW'(cur.pos_y) - SW'($signed(item.rx_byte));

	always_comb begin
		if (sum_x < 0) begin
			clamp_x = '0;
		end else if (sum_x > lim_x) begin
			clamp_x = CW'(lim_x);
		end else begin
			clamp_x = CW'(sum_x);
		end
		if (sum_y < 0) begin
			clamp_y = '0;
		end else if (sum_y > lim_y) begin
			clamp_y = CW'(lim_y);
		end else begin
			clamp_y = CW'(sum_y);
		end
	end

	always_comb begin
		nxt   = cur;
		taken = 1'b0;
		if (item.action == ps2mt_pkg::ACT_CONSUME) begin
			taken          = cur.click_flag;
			nxt.click_flag = 1'b0;
		end else begin
			unique case (cur.byte_slot)
				ps2mt_pkg::SLOT_HEADER: begin
					nxt.header_byte = item.rx_byte;
					nxt.byte_slot   = ps2mt_pkg::SLOT_DX;
				end
				ps2mt_pkg::SLOT_DX: begin
					nxt.dx_byte   = item.rx_byte;
					nxt.byte_slot = ps2mt_pkg::SLOT_DY;
				end
				default: begin
					// Final byte of the packet; a header without the valid bit is dropped.
					nxt.byte_slot = ps2mt_pkg::SLOT_HEADER;
					if (cur.header_byte[ps2mt_pkg::HDR_VALID_BIT]) begin
						nxt.pos_x       = clamp_x;
						nxt.pos_y       = clamp_y;
						nxt.left_state  = cur.header_byte[ps2mt_pkg::HDR_LEFT_BIT];
						nxt.right_state = cur.header_byte[ps2mt_pkg::HDR_RIGHT_BIT];
						if (cur.header_byte[ps2mt_pkg::HDR_LEFT_BIT]) begin
							nxt.click_flag = 1'b1;
						end
					end
				end
			endcase
		end
	end

	assign result.cursor_x      = ps2mt_pkg::CURSOR_W'(nxt.pos_x);
	assign result.cursor_y      = ps2mt_pkg::CURSOR_W'(nxt.pos_y);
	assign result.left_down     = nxt.left_state;
	assign result.right_down    = nxt.right_state;
	assign result.click_pending = nxt.click_flag;
	assign result.click_taken   = taken;

endmodule

// ===== design/ps2mt_out_buf.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker output buffer
// Two-entry result buffer that keeps the pipeline moving while the receiver
// stalls.
// ----------------------------------------------------------------------------
module ps2mt_out_buf (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  ps2mt_pkg::out_item_t  push_item,
	output logic                  space,
	output logic                  out_valid,
	input  logic                  out_ready,
	output ps2mt_pkg::out_item_t  out_item
);

	ps2mt_pkg::out_item_t head_q;
	ps2mt_pkg::out_item_t skid_q;
	logic [1:0]           count_q;
	logic                 pop;

	assign out_valid = (count_q != 2'd0);
	assign out_item  = head_q;
	assign pop       = out_valid && out_ready;
	assign space     = (count_q != 2'd2) || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= 2'd0;
		end else begin
			unique case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case ({push, pop})
			2'b10: begin
				if (count_q == 2'd0) begin
					head_q <= push_item;
				end else begin
					skid_q <= push_item;
				end
			end
			2'b01: begin
				head_q <= skid_q;
			end
			2'b11: begin
				if (count_q == 2'd1) begin
					head_q <= push_item;
				end else begin
					head_q <= skid_q;
					skid_q <= push_item;
				end
			end
			default: begin
				head_q <= head_q;
			end
		endcase
	end

endmodule

// ===== design/ps2_mouse_packet_tracker_top.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker
// Groups mouse bytes into three-byte packets and tracks cursor and buttons.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid, in_ready, in_item) carries one transfer per
// received mouse byte or per consume request. Each transfer yields exactly
// one result transfer on the output channel (out_valid, out_ready, out_item)
// holding the clamped cursor, the button states and the click flags.
// An accepted item is held in the input register; once the result buffer
// has room, the tracker state and the result buffer are written together
// and out_valid is high from that write.
// Throughput is one item per cycle as long as the receiver takes results;
// the packet state update is a single add, compare and select, so the
// tracker state loop closes through one combinational update.
// When the receiver stalls, a two-entry result buffer absorbs the items in
// flight and in_ready drops only once both entries are full.
// The clamp limits max_x and max_y are written through cfg_we, cfg_index
// and cfg_data; the user must write them only while the block is idle, as
// the block itself does not enforce this. Reset clears the pipeline and the
// buffer, places the cursor at 400,300, clears buttons and the click flag, and restores the limits to 799 and 599.
// ----------------------------------------------------------------------------
module ps2_mouse_packet_tracker_top (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  ps2mt_pkg::in_item_t               in_item,
	output logic                              out_valid,
	input  logic                              out_ready,
	output ps2mt_pkg::out_item_t              out_item,
	input  logic                              cfg_we,
	input  logic                              cfg_index,
	input  logic [ps2mt_pkg::LIMIT_W-1:0]     cfg_data
);

	logic [ps2mt_pkg::LIMIT_W-1:0] max_x_q;
	logic [ps2mt_pkg::LIMIT_W-1:0] max_y_q;
	ps2mt_pkg::trk_state_t         trk_q;
	ps2mt_pkg::trk_state_t         trk_nxt;
	ps2mt_pkg::in_item_t           item_s1;
	logic                          valid_s1;
	ps2mt_pkg::out_item_t          result;
	logic                          buf_space;
	logic                          advance;

	// The registered item is processed whenever the result buffer has room.
	assign advance  = valid_s1 && buf_space;
	assign in_ready = !valid_s1 || buf_space;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_x_q <= ps2mt_pkg::RESET_MAX_X;
			max_y_q <= ps2mt_pkg::RESET_MAX_Y;
		end else if (cfg_we) begin
			if (cfg_index == ps2mt_pkg::REG_MAX_X) begin
				max_x_q <= cfg_data;
			end else begin
				max_y_q <= cfg_data;
			end
		end
	end

	// Input register stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_item;
		end
	end

	// Tracker state, updated once per processed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			trk_q.byte_slot   <= ps2mt_pkg::SLOT_HEADER;
			trk_q.header_byte <= '0;
			trk_q.dx_byte     <= '0;
			trk_q.pos_x       <= ps2mt_pkg::RESET_POS_X;
			trk_q.pos_y       <= ps2mt_pkg::RESET_POS_Y;
			trk_q.left_state  <= 1'b0;
			trk_q.right_state <= 1'b0;
			trk_q.click_flag  <= 1'b0;
		end else if (advance) begin
			trk_q <= trk_nxt;
		end
	end

	ps2mt_update u_update (
		.item   (item_s1),
		.cur    (trk_q),
		.max_x  (max_x_q),
		.max_y  (max_y_q),
		.nxt    (trk_nxt),
		.result (result)
	);

	ps2mt_out_buf u_out_buf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (advance),
		.push_item (result),
		.space     (buf_space),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

endmodule

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// PS/2 mouse packet tracker testbench
// Drives mouse bytes and click-consume requests into the tracker. A directed
// table runs first, then random packet streams run under several clamp
// limits. Every result transfer is compared with a cycle-free model of the
// cursor, button and click state.
// ----------------------------------------------------------------------------
module testbench;
	import ps2mt_pkg::*;

	// One row of the directed table. When pinned is set, the report column
	// holds the result typed in by hand. Otherwise the tracker model decides.
	typedef struct packed {
		logic      act;
		logic [7:0] data;
		logic      pinned;
		out_item_t report;
	} probe_row_t;

	localparam out_item_t NO_REPORT = '0;
	localparam int PROBE_ROWS = 26;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_item = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_item;
	logic cfg_we = 1'b0;
	logic cfg_index = REG_MAX_X;
	logic [LIMIT_W-1:0] cfg_data = '0;

	// Tracker model state, the clamp limits it sees, and the results it
	// still expects from the block, oldest first.
	trk_state_t trk;
	logic [LIMIT_W-1:0] lim_x;
	logic [LIMIT_W-1:0] lim_y;
	out_item_t report_queue[$];

	int mismatch_count = 0;
	// Percent chance that either side starts an idle burst; zero means none.
	int idle_pct = 0;
	int stall_left = 0;
	// Direction that the random deltas push each coordinate toward.
	bit drift_x;
	bit drift_y;

	// The directed table runs from the reset state: the cursor at 400,300 and
	// the limits at 799,599. The first nine rows can be read off directly.
	// A consume with nothing pending is first. Then a full-scale packet with
	// left held moves the cursor by +127 and +128 and sets the click flag.
	// Two consumes show the flag taken once. A packet whose header lacks the
	// always-one bit is dropped whole.
	// The rest cover a header with the overflow and ninth sign bits set,
	// consumes in the middle of a packet with junk bytes beside them, and
	// packets that drive x to zero and y into its upper clamp.
	probe_row_t probe_rows [PROBE_ROWS] = '{
		'{ACT_CONSUME, 8'h00, 1'b1, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{ACT_BYTE,    8'h09, 1'b1, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{ACT_BYTE,    8'h7F, 1'b1, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0, 1'b0}},
		'{ACT_BYTE,    8'h80, 1'b1, '{12'd527, 12'd428, 1'b1, 1'b0, 1'b1, 1'b0}},
		'{ACT_CONSUME, 8'h00, 1'b1, '{12'd527, 12'd428, 1'b1, 1'b0, 1'b0, 1'b1}},
		'{ACT_CONSUME, 8'h00, 1'b1, '{12'd527, 12'd428, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{ACT_BYTE,    8'h00, 1'b1, '{12'd527, 12'd428, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{ACT_BYTE,    8'h7F, 1'b1, '{12'd527, 12'd428, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{ACT_BYTE,    8'h80, 1'b1, '{12'd527, 12'd428, 1'b1, 1'b0, 1'b0, 1'b0}},
		'{ACT_BYTE,    8'hFA, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h80, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h7F, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h0B, 1'b0, NO_REPORT},
		'{ACT_CONSUME, 8'h55, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h80, 1'b0, NO_REPORT},
		'{ACT_CONSUME, 8'hFF, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h80, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h0B, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h80, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h80, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h0B, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h80, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h80, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h0F, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h80, 1'b0, NO_REPORT},
		'{ACT_BYTE,    8'h80, 1'b0, NO_REPORT}
	};

	ps2_mouse_packet_tracker_top u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Limit the coordinate to 0..limit. The limit itself never exceeds the
	// coordinate range.
	function automatic logic [COORD_BITS-1:0] clamp_coord(input int v,
			input logic [LIMIT_W-1:0] limit);
		int lim;
		lim = (int'(limit) > int'(COORD_MASK)) ? int'(COORD_MASK) : int'(limit);
		if (v < 0)
			return '0;
		if (v > lim)
			return COORD_BITS'(lim);
		return COORD_BITS'(v);
	endfunction

	// Apply one accepted input to the tracker model and return the result
	// that the block must produce for it.
	function automatic out_item_t advance_tracker(input in_item_t it);
		out_item_t r;
		int dx;
		int dy;
		r = '0;
		if (it.action == ACT_CONSUME) begin
			r.click_taken = trk.click_flag;
			trk.click_flag = 1'b0;
		end else begin
			case (trk.byte_slot)
			SLOT_HEADER: begin
				trk.header_byte = it.rx_byte;
				trk.byte_slot = SLOT_DX;
			end
			SLOT_DX: begin
				trk.dx_byte = it.rx_byte;
				trk.byte_slot = SLOT_DY;
			end
			default: begin
				// The final byte always closes the packet, even when the
				// header turns out to be bad.
				trk.byte_slot = SLOT_HEADER;
				if (trk.header_byte[HDR_VALID_BIT]) begin
					dx = $signed(trk.dx_byte);
					dy = $signed(it.rx_byte);
					trk.pos_x = clamp_coord(int'(trk.pos_x) + dx, lim_x);
					trk.pos_y = clamp_coord(int'(trk.pos_y) - dy, lim_y);
					trk.left_state = trk.header_byte[HDR_LEFT_BIT];
					trk.right_state = trk.header_byte[HDR_RIGHT_BIT];
					if (trk.left_state)
						trk.click_flag = 1'b1;
				end
			end
			endcase
		end
		r.cursor_x = CURSOR_W'(trk.pos_x);
		r.cursor_y = CURSOR_W'(trk.pos_y);
		r.left_down = trk.left_state;
		r.right_down = trk.right_state;
		r.click_pending = trk.click_flag;
		return r;
	endfunction

	// A movement byte that mostly follows the drift, with some fully random
	// bytes mixed in.
	function automatic logic [7:0] pick_delta(input bit up);
		if ($urandom_range(0, 99) < 20)
			return 8'($urandom_range(0, 255));
		if (up)
			return 8'($urandom_range(32, 127));
		return 8'(256 - $urandom_range(32, 128));
	endfunction

	// Offer one item, hold it until the transfer, then record what it must
	// produce. A pinned report replaces the model's answer for that item,
	// while the model still advances.
	task automatic send_item(input in_item_t it, input logic pinned,
			input out_item_t report);
		out_item_t modeled;
		if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		do
			@(posedge clk);
		while (!in_ready);
		modeled = advance_tracker(it);
		report_queue.push_back(pinned ? report : modeled);
	endtask

	// Stop offering items and wait until every expected result has arrived.
	task automatic drain_reports();
		in_valid <= 1'b0;
		while (report_queue.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_limit(input logic idx, input logic [LIMIT_W-1:0] v);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		@(posedge clk);
		if (idx == REG_MAX_X)
			lim_x = v;
		else
			lim_y = v;
	endtask

	task automatic check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatch_count++;
		end
	endtask

	// The receiver stalls in random bursts. The counter
	// holds the cycles left in the current burst after this one.
	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
			stall_left <= $urandom_range(0, 6);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Each result transfer is checked against the oldest expected result.
	always @(posedge clk) begin : check_reports
		out_item_t want;
		if (arst_n && out_valid && out_ready) begin
			if (report_queue.size() == 0) begin
				$error("unexpected result transfer: %h", out_item);
				mismatch_count++;
			end else begin
				want = report_queue.pop_front();
				check_field("cursor_x", want.cursor_x, out_item.cursor_x);
				check_field("cursor_y", want.cursor_y, out_item.cursor_y);
				check_field("left_down", want.left_down, out_item.left_down);
				check_field("right_down", want.right_down, out_item.right_down);
				check_field("click_pending", want.click_pending, out_item.click_pending);
				check_field("click_taken", want.click_taken, out_item.click_taken);
			end
		end
	end

	initial begin : stimulus
		in_item_t it;
		int phase;
		int phase_items;
		int flip_odds;

		trk = '0;
		trk.pos_x = RESET_POS_X;
		trk.pos_y = RESET_POS_Y;
		lim_x = RESET_MAX_X;
		lim_y = RESET_MAX_Y;

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		// The directed table runs under the reset limits, with some idling.
		idle_pct = 15;
		foreach (probe_rows[i]) begin
			it.action = probe_rows[i].act;
			it.rx_byte = probe_rows[i].data;
			send_item(it, probe_rows[i].pinned, probe_rows[i].report);
		end

		// Random phases. The limits change only once the block has gone
		// quiet. The extremes come first: zero, then full range. Phase 1 is
		// longer and drifts steadily upward, so the cursor climbs from the
		// origin into the full-range clamp. The last phase runs without any
		// idling.
		for (phase = 0; phase < 7; phase++) begin
			drain_reports();
			phase_items = 240;
			flip_odds = 16;
			drift_x = 1'($urandom_range(0, 1));
			drift_y = 1'($urandom_range(0, 1));
			case (phase)
			0: begin
				write_limit(REG_MAX_X, '0);
				write_limit(REG_MAX_Y, '0);
				idle_pct = 20;
			end
			1: begin
				write_limit(REG_MAX_X, '1);
				write_limit(REG_MAX_Y, '1);
				idle_pct = 40;
				phase_items = 400;
				flip_odds = 0;
				drift_x = 1'b1;
				drift_y = 1'b1;
			end
			3: begin
				write_limit(REG_MAX_X, RESET_MAX_X);
				write_limit(REG_MAX_Y, LIMIT_W'($urandom_range(1, 64)));
				idle_pct = 0;
			end
			5: begin
				write_limit(REG_MAX_X, '1);
				write_limit(REG_MAX_Y, '0);
				idle_pct = 15;
			end
			default: begin
				write_limit(REG_MAX_X, LIMIT_W'($urandom_range(0, 4095)));
				write_limit(REG_MAX_Y, LIMIT_W'($urandom_range(0, 4095)));
				idle_pct = (phase == 6) ? 0 : 10 + 5 * phase;
			end
			endcase
			cfg_we <= 1'b0;

			// Mostly well-formed packets with random content. Some headers
			// lack the always-one bit, so the whole packet is dropped.
			// Consumes land anywhere, including in the middle of a packet.
			repeat (phase_items) begin
				if ($urandom_range(0, 99) < 12) begin
					it.action = ACT_CONSUME;
					it.rx_byte = 8'($urandom_range(0, 255));
				end else begin
					it.action = ACT_BYTE;
					case (trk.byte_slot)
					SLOT_HEADER: begin
						it.rx_byte = 8'($urandom_range(0, 255));
						if ($urandom_range(0, 99) < 85)
							it.rx_byte[HDR_VALID_BIT] = 1'b1;
						if (flip_odds != 0 && $urandom_range(1, flip_odds) == 1)
							drift_x = !drift_x;
						if (flip_odds != 0 && $urandom_range(1, flip_odds) == 1)
							drift_y = !drift_y;
					end
					SLOT_DX: it.rx_byte = pick_delta(drift_x);
					// The block subtracts the Y delta, so an upward drift
					// needs negative bytes.
					default: it.rx_byte = pick_delta(!drift_y);
					endcase
				end
				send_item(it, 1'b0, NO_REPORT);
			end
		end

		// Let the last results arrive. The extra cycles catch any result
		// that was never expected.
		drain_reports();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0)
			$display("ps2_mouse_packet_tracker_top: match");
		else
			$display("ps2_mouse_packet_tracker_top: mismatch");
		$finish;
	end

	// Watchdog: far beyond the slowest correct run.
	initial begin
		#3000000;
		$display("ps2_mouse_packet_tracker_top: mismatch");
		$finish;
	end

endmodule
